>>> rtl/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle core.
`default_nettype none

package q2e_pkg;

   // Input and output field widths
   localparam int QW      = 32;
   localparam int PITCH_W = 15;
   localparam int ROLL_W  = 16;
   localparam int YAW_W   = 16;

   // Defaults for the top level parameters
   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 7;

   // Internal datapath widths
   localparam int PW         = 64;  // component products, Q60
   localparam int XW         = 37;  // CORDIC x / y
   localparam int ZW         = 34;  // CORDIC angle, Q30 radians
   localparam int SQ_W       = 62;  // square root radicand and partial root
   localparam int SQRT_STEPS = 31;  // two radicand bits per cell, top bit 2^60

   localparam logic signed [ZW-1:0] HALF_PI = ZW'(1686629713);

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } vec_type;

   typedef struct packed {
      logic [SQ_W-1:0] n;
      logic [SQ_W-1:0] res;
   } sqrt_type;

   typedef struct packed {
      logic signed [QW-1:0] a;
      logic signed [XW-1:0] ry;
      logic signed [XW-1:0] rx;
      logic signed [XW-1:0] yy;
      logic signed [XW-1:0] yx;
   } side_type;

   // atan(2^-i) in Q30 radians
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      case (idx)
         0: return ZW'(843314857);
         1: return ZW'(497837829);
         2: return ZW'(263043837);
         3: return ZW'(133525159);
         4: return ZW'(67021687);
         5: return ZW'(33543516);
         6: return ZW'(16775851);
         7: return ZW'(8388437);
         8: return ZW'(4194283);
         9: return ZW'(2097149);
         10: return ZW'(1048576);
         11: return ZW'(524288);
         12: return ZW'(262144);
         13: return ZW'(131072);
         14: return ZW'(65536);
         15: return ZW'(32768);
         16: return ZW'(16384);
         17: return ZW'(8192);
         18: return ZW'(4096);
         19: return ZW'(2048);
         20: return ZW'(1024);
         21: return ZW'(512);
         22: return ZW'(256);
         23: return ZW'(128);
         24: return ZW'(64);
         25: return ZW'(32);
         26: return ZW'(16);
         27: return ZW'(8);
         28: return ZW'(4);
         29: return ZW'(2);
         default: return '0;
      endcase
   endfunction

   // Quadrant fold for vectors in the left half plane, plus the zero flag
   function automatic vec_type pre_rotate(input logic signed [XW-1:0] y,
                                          input logic signed [XW-1:0] x);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      if (x[XW-1]) begin
         if (!y[XW-1]) begin
            v.x = y;
            v.y = -x;
            v.z = HALF_PI;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -HALF_PI;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/q2e_req_if.sv
// Request channel: one quaternion per transfer.
`default_nettype none

interface q2e_req_if;
   import q2e_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] quat_w;
   logic signed [QW-1:0] quat_x;
   logic signed [QW-1:0] quat_y;
   logic signed [QW-1:0] quat_z;
   logic                 quat_present;

   modport source(output valid, quat_w, quat_x, quat_y, quat_z, quat_present,
                  input ready);
   modport sink(input valid, quat_w, quat_x, quat_y, quat_z, quat_present,
                output ready);
endinterface

`default_nettype wire

>>> rtl/q2e_rsp_if.sv
// Response channel: pitch, roll and yaw in fixed-point degrees.
`default_nettype none

interface q2e_rsp_if;
   import q2e_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [PITCH_W-1:0] pitch_angle;
   logic signed [ROLL_W-1:0]  roll_angle;
   logic signed [YAW_W-1:0]   yaw_angle;

   modport source(output valid, pitch_angle, roll_angle, yaw_angle, input ready);
   modport sink(input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

`default_nettype wire

>>> rtl/q2e_sqrt_cell.sv
// One restoring square root step: two radicand bits per cell.
`default_nettype none

module q2e_sqrt_cell #(
   parameter int BIT_POS = 60
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire q2e_pkg::sqrt_type  d_in,
   output      q2e_pkg::sqrt_type  d_out
);
   import q2e_pkg::*;

   localparam logic [SQ_W-1:0] BIT_V = SQ_W'(1) << BIT_POS;

   sqrt_type        out_ff;
   sqrt_type        out_in;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = d_in.res + BIT_V;
      if (d_in.n >= trial) begin
         out_in.n   = d_in.n - trial;
         out_in.res = (d_in.res >> 1) + BIT_V;
      end else begin
         out_in.n   = d_in.n;
         out_in.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign d_out = out_ff;

endmodule

`default_nettype wire

>>> rtl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with a fixed shift.
`default_nettype none

module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire q2e_pkg::vec_type  d_in,
   output      q2e_pkg::vec_type  d_out
);
   import q2e_pkg::*;

   localparam logic signed [ZW-1:0] ANG = atan_entry(STEP);

   vec_type              out_ff;
   vec_type              out_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   always_comb begin
      xs          = d_in.x >>> STEP;
      ys          = d_in.y >>> STEP;
      out_in.zero = d_in.zero;
      if (!d_in.y[XW-1]) begin
         out_in.x = d_in.x + ys;
         out_in.y = d_in.y - xs;
         out_in.z = d_in.z + ANG;
      end else begin
         out_in.x = d_in.x - ys;
         out_in.y = d_in.y + xs;
         out_in.z = d_in.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign d_out = out_ff;

endmodule

`default_nettype wire

>>> rtl/q2e_deg_unit.sv
// Radians (Q30) to rounded, saturated fixed-point degrees, three stages.
`default_nettype none

module q2e_deg_unit #(
   parameter int OUT_W     = 16,
   parameter int FRAC_BITS = 7
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [q2e_pkg::ZW-1:0]  angle,
   output      logic signed [OUT_W-1:0]        deg
);
   import q2e_pkg::*;

   localparam int PROD_W = ZW + 10 + FRAC_BITS;
   localparam int TW     = PROD_W - 30;
   localparam int MW     = 2 * TW;
   localparam int RW     = TW + 4;
   localparam int CW     = TW + OUT_W;
   localparam logic [TW-1:0] RECIP = TW'((64'd1 << TW) / 64'd10);
   localparam logic [CW-1:0] LIM   = CW'(1) << (OUT_W - 1);

   logic [TW-1:0]     t1_ff, t1_in;
   logic              neg1_ff;
   logic [MW-1:0]     prod2_ff, prod2_in;
   logic [TW-1:0]     t2_ff;
   logic              neg2_ff;
   logic [OUT_W-1:0]  deg_ff, deg_in;

   logic [ZW-1:0]     mag;
   logic [PROD_W-1:0] num;
   logic [TW-1:0]     q0;
   logic [TW-1:0]     q;
   logic [RW-1:0]     rem;
   logic [CW-1:0]     qx;
   logic [CW-1:0]     qs;
   logic [CW-1:0]     qn;

   // Stage 1: |angle| * 573 * 2^F + half of 10 * 2^30, drop 30 bits
   always_comb begin
      mag   = angle[ZW-1] ? ZW'(-angle) : ZW'(angle);
      num   = (PROD_W'(mag) * PROD_W'(573)) << FRAC_BITS;
      num   = num + (PROD_W'(5) << 30);
      t1_in = num[PROD_W-1:30];
   end

   // Stage 2: reciprocal multiply for the divide by ten
   assign prod2_in = MW'(t1_ff) * MW'(RECIP);

   // Stage 3: one-step correction, saturation and sign
   always_comb begin
      q0  = prod2_ff[MW-1:TW];
      rem = RW'(t2_ff) - RW'(q0) * RW'(10);
      q   = (rem >= RW'(10)) ? q0 + TW'(1) : q0;
      qx  = CW'(q);
      if (neg2_ff) begin
         qs     = (qx > LIM) ? LIM : qx;
         qn     = ~qs + CW'(1);
         deg_in = qn[OUT_W-1:0];
      end else begin
         qs     = (qx > LIM - CW'(1)) ? LIM - CW'(1) : qx;
         qn     = qs;
         deg_in = qn[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff    <= t1_in;
         neg1_ff  <= angle[ZW-1];
         prod2_ff <= prod2_in;
         t2_ff    <= t1_ff;
         neg2_ff  <= neg1_ff;
         deg_ff   <= deg_in;
      end
   end

   assign deg = deg_ff;

endmodule

`default_nettype wire

>>> rtl/quaternion_to_euler_angles_core.sv
// Top level of the quaternion to Euler angle converter.
`default_nettype none

// Converts a unit quaternion (four Q30 signed components, each clamped to
// +/-1) into pitch = asin(2(wy - xz)), roll = atan2(2(yz + wx),
// 1 - 2(x^2 + y^2)) and yaw = atan2(2(xy + wz), w^2 + x^2 - y^2 - z^2),
// scaled by 57.3 into signed degrees with ANGLE_FRAC_BITS fraction bits,
// rounded half away from zero and clamped to the field range. A request
// with quat_present low is taken and produces no response. The datapath
// is one long pipeline of cells: component products, sums, a 31-cell
// square root chain for the pitch cosine, a quadrant fold, CORDIC_STEPS
// vectoring CORDIC cells per angle and a three-stage degree scaler.
// Throughput is one request per clock while the pipeline is not held.
// The whole pipeline holds only when the response register is full, its
// response is not taken and a result sits in the last stage; then no
// stage moves, bubbles included. No state survives between requests and
// no start-up sweep is needed.

module quaternion_to_euler_angles_core #(
   parameter int CORDIC_STEPS    = q2e_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   q2e_req_if.sink    req_chan,
   q2e_rsp_if.source  rsp_chan
);
   import q2e_pkg::*;

   // Stage map: 0 input, 1 products, 2 sums, 3 a^2, 4 radicand,
   // 5..35 square root, 36 fold, then CORDIC, then three degree stages.
   localparam int NST      = 40 + CORDIC_STEPS;
   localparam int SIDE_LEN = SQRT_STEPS + 3;
   localparam logic signed [QW-1:0] ONE_Q30   = QW'(1073741824);
   localparam logic signed [QW-1:0] M_ONE_Q30 = -ONE_Q30;
   localparam logic signed [PW-1:0] ONE_P     = PW'(1073741824);
   localparam logic signed [PW-1:0] M_ONE_P   = -ONE_P;

   function automatic logic signed [QW-1:0] clamp_one(input logic signed [QW-1:0] v);
      if (v > ONE_Q30) begin
         return ONE_Q30;
      end else if (v < M_ONE_Q30) begin
         return M_ONE_Q30;
      end
      return v;
   endfunction

   // Pipeline control
   logic           en;
   logic           in_take;
   logic [NST-1:0] vld_ff, vld_in;
   logic           out_load;

   // Stage 0: clamped components
   logic signed [QW-1:0] w_ff, x_ff, y_ff, z_ff;

   // Stage 1: products, Q60
   logic signed [PW-1:0] p_wy_ff, p_xz_ff, p_yz_ff, p_wx_ff, p_xx_ff;
   logic signed [PW-1:0] p_yy_ff, p_xy_ff, p_wz_ff, p_ww_ff, p_zz_ff;

   // Stage 2 onward: operands riding beside the square root chain
   side_type             side_ff [SIDE_LEN];
   side_type             side_in [SIDE_LEN];
   logic signed [PW-1:0] a_full, ry_full, rx_full, yy_full, yx_full;

   // Stages 3, 4: a^2 and radicand
   logic [SQ_W-1:0]      asq_ff, asq_in;
   logic signed [PW-1:0] asq_full;
   sqrt_type             sq0_ff, sq0_in;
   sqrt_type             sq [SQRT_STEPS+1];

   // Quadrant fold and CORDIC lanes: 0 pitch, 1 roll, 2 yaw
   vec_type              pre_ff [3];
   vec_type              pre_in [3];
   vec_type              cv [3][CORDIC_STEPS+1];
   logic signed [ZW-1:0] ang [3];
   logic signed [PITCH_W-1:0] pitch_deg;
   logic signed [ROLL_W-1:0]  roll_deg;
   logic signed [YAW_W-1:0]   yaw_deg;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [YAW_W-1:0]   yaw_ff;

   // Advance unless a finished result would overwrite a waiting response
   assign en             = !rsp_valid_ff || rsp_chan.ready || !vld_ff[NST-1];
   assign req_chan.ready = en;
   assign in_take        = req_chan.valid && req_chan.quat_present;
   assign vld_in         = {vld_ff[NST-2:0], in_take};
   assign out_load       = en && vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 2 sums; every reduction is a floor shift
   always_comb begin
      a_full  = (p_wy_ff - p_xz_ff) >>> 29;
      ry_full = (p_yz_ff + p_wx_ff) >>> 29;
      rx_full = ONE_P - ((p_xx_ff + p_yy_ff) >>> 29);
      yy_full = (p_xy_ff + p_wz_ff) >>> 29;
      yx_full = (p_ww_ff + p_xx_ff - p_yy_ff - p_zz_ff) >>> 30;

      if (a_full > ONE_P) begin
         side_in[0].a = ONE_Q30;
      end else if (a_full < M_ONE_P) begin
         side_in[0].a = M_ONE_Q30;
      end else begin
         side_in[0].a = a_full[QW-1:0];
      end
      side_in[0].ry = ry_full[XW-1:0];
      side_in[0].rx = rx_full[XW-1:0];
      side_in[0].yy = yy_full[XW-1:0];
      side_in[0].yx = yx_full[XW-1:0];
      for (int j = 1; j < SIDE_LEN; j++) begin
         side_in[j] = side_ff[j-1];
      end
   end

   // Radicand 2^60 - a^2 (a is clamped, so it never goes negative)
   always_comb begin
      asq_full   = PW'(side_ff[0].a) * PW'(side_ff[0].a);
      asq_in     = asq_full[SQ_W-1:0];
      sq0_in.n   = (SQ_W'(1) << 60) - asq_ff;
      sq0_in.res = '0;
   end

   assign sq[0] = sq0_ff;

   // Fold each (y, x) pair into the right half plane
   always_comb begin
      pre_in[0] = pre_rotate(XW'(side_ff[SIDE_LEN-1].a),
                             XW'(sq[SQRT_STEPS].res[QW-2:0]));
      pre_in[1] = pre_rotate(side_ff[SIDE_LEN-1].ry, side_ff[SIDE_LEN-1].rx);
      pre_in[2] = pre_rotate(side_ff[SIDE_LEN-1].yy, side_ff[SIDE_LEN-1].yx);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff    <= clamp_one(req_chan.quat_w);
         x_ff    <= clamp_one(req_chan.quat_x);
         y_ff    <= clamp_one(req_chan.quat_y);
         z_ff    <= clamp_one(req_chan.quat_z);
         p_wy_ff <= PW'(w_ff) * PW'(y_ff);
         p_xz_ff <= PW'(x_ff) * PW'(z_ff);
         p_yz_ff <= PW'(y_ff) * PW'(z_ff);
         p_wx_ff <= PW'(w_ff) * PW'(x_ff);
         p_xx_ff <= PW'(x_ff) * PW'(x_ff);
         p_yy_ff <= PW'(y_ff) * PW'(y_ff);
         p_xy_ff <= PW'(x_ff) * PW'(y_ff);
         p_wz_ff <= PW'(w_ff) * PW'(z_ff);
         p_ww_ff <= PW'(w_ff) * PW'(w_ff);
         p_zz_ff <= PW'(z_ff) * PW'(z_ff);
         side_ff <= side_in;
         asq_ff  <= asq_in;
         sq0_ff  <= sq0_in;
         pre_ff  <= pre_in;
      end
   end

   // Square root chain, root lands in res after the last cell
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      q2e_sqrt_cell #(
         .BIT_POS(60 - 2 * k)
      ) u_cell (
         .clock(clock),
         .en   (en),
         .d_in (sq[k]),
         .d_out(sq[k+1])
      );
   end

   // CORDIC rows, one per angle
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign cv[l][0] = pre_ff[l];
      for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
         q2e_cordic_cell #(
            .STEP(j)
         ) u_cell (
            .clock(clock),
            .en   (en),
            .d_in (cv[l][j]),
            .d_out(cv[l][j+1])
         );
      end
      // atan2 of the zero vector is zero
      assign ang[l] = cv[l][CORDIC_STEPS].zero ? '0 : cv[l][CORDIC_STEPS].z;
   end

   q2e_deg_unit #(
      .OUT_W    (PITCH_W),
      .FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_deg_pitch (
      .clock(clock),
      .en   (en),
      .angle(ang[0]),
      .deg  (pitch_deg)
   );

   q2e_deg_unit #(
      .OUT_W    (ROLL_W),
      .FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_deg_roll (
      .clock(clock),
      .en   (en),
      .angle(ang[1]),
      .deg  (roll_deg)
   );

   q2e_deg_unit #(
      .OUT_W    (YAW_W),
      .FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_deg_yaw (
      .clock(clock),
      .en   (en),
      .angle(ang[2]),
      .deg  (yaw_deg)
   );

   // Response register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         pitch_ff <= pitch_deg;
         roll_ff  <= roll_deg;
         yaw_ff   <= yaw_deg;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pitch_angle = pitch_ff;
   assign rsp_chan.roll_angle  = roll_ff;
   assign rsp_chan.yaw_angle   = yaw_ff;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the quaternion to Euler angle core.
`timescale 1ns / 1ps

module tb_top;
   import q2e_pkg::*;

   localparam int STEPS     = CORDIC_STEPS_DEF;
   localparam int FRAC      = ANGLE_FRAC_BITS_DEF;
   localparam int LATENCY   = 41 + STEPS;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 1100;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   typedef struct {
      logic signed [QW-1:0] w, x, y, z;
      logic                 present;
   } quat_req_type;

   typedef struct {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ROLL_W-1:0]  roll;
      logic signed [YAW_W-1:0]   yaw;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   q2e_req_if req_chan ();
   q2e_rsp_if rsp_chan ();

   quaternion_to_euler_angles_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   quat_req_type pending_reqs[$];
   euler_type    expected_angles[$];
   int        mismatches = 0;
   int        watchdog   = 0;
   int        burst_left = 0;
   int        gap_left   = 0;
   int        stall_phase = 0;

   // ---------------------------------------------------------------------
   // Predictor: fixed-point conversion, bit exact
   // ---------------------------------------------------------------------
   function automatic longint clamp_unit(input logic signed [QW-1:0] raw);
      longint v;
      v = raw;
      if (v > ONE_Q30) v = ONE_Q30;
      if (v < -ONE_Q30) v = -ONE_Q30;
      return v;
   endfunction

   // >>> on a signed longint is a floor shift
   function automatic longint floor_div(input longint v, input int n);
      return v >>> n;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(root);
   endfunction

   function automatic longint atan_q30(input int i);
      longint tbl [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
         256, 128, 64, 32, 16, 8, 4, 2};
      return tbl[i];
   endfunction

   function automatic longint vector_angle(input longint y, input longint x);
      longint ang, t, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      // fold left half plane by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; ang = 1686629713;
         end else begin
            t = x; x = -y; y = t; ang = -1686629713;
         end
      end
      for (int i = 0; i < STEPS && i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; ang = ang + atan_q30(i);
         end else begin
            x = x - ys; y = y + xs; ang = ang - atan_q30(i);
         end
      end
      return ang;
   endfunction

   // radians Q30 -> degrees (factor 57.3), half away from zero, clamped
   function automatic longint to_deg(input longint ang, input int width);
      longint unsigned mag, den, q, lim;
      bit neg;
      neg = ang < 0;
      mag = neg ? -ang : ang;
      den = 64'd10 << 30;
      q   = ((mag * 573) << FRAC) + den / 2;
      q   = q / den;
      lim = 64'd1 << (width - 1);
      if (neg) begin
         if (q > lim) q = lim;
         return -longint'(q);
      end
      if (q > lim - 1) q = lim - 1;
      return longint'(q);
   endfunction

   function automatic euler_type predict_euler(input quat_req_type r);
      longint w, x, y, z, a, ry, rx, yy, yx;
      longint unsigned cosv;
      euler_type e;
      w = clamp_unit(r.w);
      x = clamp_unit(r.x);
      y = clamp_unit(r.y);
      z = clamp_unit(r.z);
      a = floor_div(w * y - x * z, 29);
      if (a > ONE_Q30) a = ONE_Q30;
      if (a < -ONE_Q30) a = -ONE_Q30;
      cosv = int_sqrt((64'd1 << 60) - longint'(a * a));
      ry = floor_div(y * z + w * x, 29);
      rx = ONE_Q30 - floor_div(x * x + y * y, 29);
      yy = floor_div(x * y + w * z, 29);
      yx = floor_div(w * w + x * x - y * y - z * z, 30);
      e.pitch = PITCH_W'(to_deg(vector_angle(a, longint'(cosv)), PITCH_W));
      e.roll  = ROLL_W'(to_deg(vector_angle(ry, rx), ROLL_W));
      e.yaw   = YAW_W'(to_deg(vector_angle(yy, yx), YAW_W));
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------
   function automatic quat_req_type make_quat(input longint w, input longint x,
                                              input longint y, input longint z,
                                              input bit present);
      quat_req_type r;
      r.w = QW'(w); r.x = QW'(x); r.y = QW'(y); r.z = QW'(z);
      r.present = present;
      return r;
   endfunction

   // roughly unit quaternion with random direction
   function automatic quat_req_type random_unit_quat();
      real c[4], norm;
      longint v[4];
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = (real'($urandom_range(2000000)) - 1000000.0) / 1000000.0;
         norm += c[i] * c[i];
      end
      if (norm < 1.0e-6) begin
         c[0] = 1.0; norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) begin
         v[i] = longint'(c[i] / norm * 1073741824.0);
         // small perturbation keeps the low bits busy
         v[i] += longint'($urandom_range(64)) - 32;
      end
      return make_quat(v[0], v[1], v[2], v[3], 1'b1);
   endfunction

   function automatic quat_req_type random_raw_quat();
      return make_quat(longint'($signed($urandom())), longint'($signed($urandom())),
                       longint'($signed($urandom())), longint'($signed($urandom())),
                       1'($urandom_range(1)));
   endfunction

   initial begin
      quat_req_type r;
      longint h;
      h = 64'd759250125;  // ~ 1/sqrt(2) in Q30
      // identity and the axis-aligned rotations
      pending_reqs.push_back(make_quat(ONE_Q30, 0, 0, 0, 1'b1));
      pending_reqs.push_back(make_quat(-ONE_Q30, 0, 0, 0, 1'b1));
      pending_reqs.push_back(make_quat(0, ONE_Q30, 0, 0, 1'b1));
      pending_reqs.push_back(make_quat(0, 0, ONE_Q30, 0, 1'b1));
      pending_reqs.push_back(make_quat(0, 0, 0, ONE_Q30, 1'b1));
      pending_reqs.push_back(make_quat(0, 0, 0, -ONE_Q30, 1'b1));
      // gimbal lock, pitch +/-90, then quarter turns in roll and yaw
      pending_reqs.push_back(make_quat(h, 0, h, 0, 1'b1));
      pending_reqs.push_back(make_quat(h, 0, -h, 0, 1'b1));
      pending_reqs.push_back(make_quat(h, h, 0, 0, 1'b1));
      pending_reqs.push_back(make_quat(h, 0, 0, -h, 1'b1));
      // zero quaternion: the yaw comes from atan2(0, 0)
      pending_reqs.push_back(make_quat(0, 0, 0, 0, 1'b1));
      // components beyond one get clamped
      pending_reqs.push_back(make_quat(32'sh7fffffff, 32'sh7fffffff,
                                       32'sh7fffffff, 32'sh7fffffff, 1'b1));
      pending_reqs.push_back(make_quat(-32'sh80000000, -32'sh80000000,
                                       -32'sh80000000, -32'sh80000000, 1'b1));
      pending_reqs.push_back(make_quat(32'sh7fffffff, -32'sh80000000,
                                       32'sh7fffffff, -32'sh80000000, 1'b1));
      // non-unit: asin argument saturates
      pending_reqs.push_back(make_quat(ONE_Q30, ONE_Q30, ONE_Q30, -ONE_Q30, 1'b1));
      pending_reqs.push_back(make_quat(ONE_Q30, ONE_Q30, -ONE_Q30, ONE_Q30, 1'b1));
      // absent quaternions, then a tiny present one
      pending_reqs.push_back(make_quat(ONE_Q30, 0, 0, 0, 1'b0));
      pending_reqs.push_back(make_quat(-1, -1, -1, -1, 1'b0));
      pending_reqs.push_back(make_quat(1, -1, 1, -1, 1'b1));
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(9) < 8) r = random_unit_quat();
         else r = random_raw_quat();
         pending_reqs.push_back(r);
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts and gaps; pauses once for a full drain
   // ---------------------------------------------------------------------
   int  sent = 0;
   bit  drained_once = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.quat_w       <= '0;
         req_chan.quat_x       <= '0;
         req_chan.quat_y       <= '0;
         req_chan.quat_z       <= '0;
         req_chan.quat_present <= 1'b0;
      end else begin : drive
         bit fire, load;
         fire = req_chan.valid && req_chan.ready;
         if (fire) begin
            expected_push(pending_reqs.pop_front());
            sent++;
         end
         load = 1'b0;
         if (!req_chan.valid || fire) begin
            if (sent == 400 && !drained_once) begin
               // hold off until every outstanding result has come back
               if (expected_angles.size() == 0) drained_once = 1'b1;
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               load = 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(40, 1);
                  if ($urandom_range(3) != 0) gap_left = $urandom_range(6);
               end
               burst_left--;
            end
            req_chan.valid <= load;
            if (load) begin
               req_chan.quat_w       <= pending_reqs[0].w;
               req_chan.quat_x       <= pending_reqs[0].x;
               req_chan.quat_y       <= pending_reqs[0].y;
               req_chan.quat_z       <= pending_reqs[0].z;
               req_chan.quat_present <= pending_reqs[0].present;
            end
         end
      end
   end

   function automatic void expected_push(input quat_req_type r);
      if (r.present) expected_angles.push_back(predict_euler(r));
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: receiver stall pattern and field compare
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase    <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_angles.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response p=%0d r=%0d y=%0d",
                           rsp_chan.pitch_angle, rsp_chan.roll_angle,
                           rsp_chan.yaw_angle);
            end else begin : cmp
               euler_type e;
               e = expected_angles.pop_front();
               if (e.pitch !== rsp_chan.pitch_angle || e.roll !== rsp_chan.roll_angle
                   || e.yaw !== rsp_chan.yaw_angle) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp p=%0d r=%0d y=%0d got p=%0d r=%0d y=%0d",
                              e.pitch, e.roll, e.yaw, rsp_chan.pitch_angle,
                              rsp_chan.roll_angle, rsp_chan.yaw_angle);
               end
            end
         end
         // stall pattern: long open stretches, then choppy phases
         stall_phase <= (stall_phase + 1) % 300;
         if (stall_phase < 100) rsp_chan.ready <= 1'b1;
         else if (stall_phase < 200) rsp_chan.ready <= ($urandom_range(3) != 0);
         else rsp_chan.ready <= ($urandom_range(3) == 0);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready))
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && expected_angles.size() == 0 || watchdog >= WDOG_MAX);
      if (watchdog < WDOG_MAX) begin
         repeat (LATENCY + 20) @(posedge clock);
      end
      if (watchdog >= WDOG_MAX) begin
         $display("timeout");
         $display("== FAIL ==");
      end else if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/q2e_pkg.sv
rtl/q2e_req_if.sv
rtl/q2e_rsp_if.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/q2e_deg_unit.sv
rtl/quaternion_to_euler_angles_core.sv
bench/tb_top.sv
